@@ hdl/rbs_pkg.sv @@
// Package for the robot bytecode sequencer.
// Holds opcodes, LED codes, the result item type and the duty helpers.
// No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

  // Instruction opcodes
  localparam logic [7:0] OP_START      = 8'h01;
  localparam logic [7:0] OP_WAIT       = 8'h02;
  localparam logic [7:0] OP_NOTE_STOP  = 8'h09;
  localparam logic [7:0] OP_LED_ON     = 8'h44;
  localparam logic [7:0] OP_LED_OFF    = 8'h45;
  localparam logic [7:0] OP_NOTE_PLAY  = 8'h48;
  localparam logic [7:0] OP_STOP_A     = 8'h60;
  localparam logic [7:0] OP_STOP_B     = 8'h61;
  localparam logic [7:0] OP_FORWARD    = 8'h62;
  localparam logic [7:0] OP_REVERSE    = 8'h63;
  localparam logic [7:0] OP_TURN_RIGHT = 8'h64;
  localparam logic [7:0] OP_TURN_LEFT  = 8'h65;
  localparam logic [7:0] OP_LOOP_BEGIN = 8'hC0;
  localparam logic [7:0] OP_LOOP_END   = 8'hC1;
  localparam logic [7:0] OP_END        = 8'hFF;

  // LED codes
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_GREEN = 2'd1;
  localparam logic [1:0] LED_RED   = 2'd2;

  // Motor direction codes: bit 0 motor A, bit 1 motor B, 1 is reverse
  localparam logic [1:0] DIRS_FWD   = 2'b00;
  localparam logic [1:0] DIRS_RIGHT = 2'b01;
  localparam logic [1:0] DIRS_LEFT  = 2'b10;
  localparam logic [1:0] DIRS_REV   = 2'b11;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [9:0] TURN_MS   = 10'd550;
  localparam logic [9:0] SETTLE_MS = 10'd500;

  // Configuration register indexes and reset values
  localparam logic REG_SIDE_B_TRIM = 1'b0;
  localparam logic REG_WAIT_SCALE  = 1'b1;
  localparam logic [6:0] SIDE_B_TRIM_RST = 7'd10;
  localparam logic [7:0] WAIT_SCALE_RST  = 8'd25;

  typedef struct packed {
    logic [15:0] next_address;
    logic        halted;
    logic [1:0]  led_color;
    logic        dir_a;
    logic        dir_b;
    logic [6:0]  duty_a;
    logic [6:0]  duty_b;
    logic        sound_on;
    logic [7:0]  note;
    logic [15:0] timer_wait;
    logic [9:0]  delay_ms;
    logic        last;
  } result_t;

  // arg*100/255 as reciprocal form: x/255 == (x + (x>>8) + 1) >> 8 for x up to 25500
  function automatic logic [6:0] duty_pct(input logic [7:0] arg);
    logic [15:0] prod;
    logic [15:0] quot;
    prod = {8'd0, arg} * 16'd100;
    quot = (prod + (prod >> 8) + 16'd1) >> 8;
    return quot[6:0];
  endfunction

  // Side B duty: subtract correction, floor at zero
  function automatic logic [6:0] side_b_duty(input logic [6:0] pct, input logic [6:0] corr);
    return (pct > corr) ? (pct - corr) : 7'd0;
  endfunction

endpackage

@@ hdl/rbs_instr_if.sv @@
// Instruction channel: valid/ready handshake carrying opcode and operand.
// No dependencies.
`timescale 1ns / 1ps

interface rbs_instr_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

@@ hdl/rbs_result_if.sv @@
// Result channel: valid/ready handshake carrying one sequencer result item.
// Depends on rbs_pkg.
`timescale 1ns / 1ps

interface rbs_result_if
  import rbs_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [15:0] next_address;
  logic        halted;
  logic [1:0]  led_color;
  logic        dir_a;
  logic        dir_b;
  logic [6:0]  duty_a;
  logic [6:0]  duty_b;
  logic        sound_on;
  logic [7:0]  note;
  logic [15:0] timer_wait;
  logic [9:0]  delay_ms;
  logic        last;

  modport source (output valid, output next_address, output halted, output led_color,
                  output dir_a, output dir_b, output duty_a, output duty_b,
                  output sound_on, output note, output timer_wait, output delay_ms,
                  output last, input ready);
  modport sink   (input valid, input next_address, input halted, input led_color,
                  input dir_a, input dir_b, input duty_a, input duty_b,
                  input sound_on, input note, input timer_wait, input delay_ms,
                  input last, output ready);
endinterface

@@ hdl/robot_bytecode_sequencer.sv @@
// Robot bytecode sequencer top level: decode, state update, result buffer, APB registers.
// Depends on rbs_pkg, rbs_instr_if and rbs_result_if.
// Latency: the first result is valid the cycle after its instruction transaction.
// Throughput: one instruction per cycle while result_o.ready; a turn gives two
//   results and holds the input while its second result is in the holding register.
// Reset: rst_ni asynchronous, active low; clears all program state and the
//   result buffer and loads the side B trim with 10 and wait_scale with 25.
`timescale 1ns / 1ps

module robot_bytecode_sequencer
  import rbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rbs_instr_if.sink   instr_i,
  rbs_result_if.source result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [6:0] corr_q;
  logic [7:0] scale_q;

  // Program state
  logic [15:0] pa_q, pa_d;
  logic        started_q, started_d;
  logic        stopped_q, stopped_d;
  logic [15:0] loop_start_q, loop_start_d;
  logic [7:0]  loop_rem_q, loop_rem_d;
  logic [1:0]  led_q, led_d;
  logic [1:0]  dirs_q, dirs_d;
  logic [6:0]  duty_a_q, duty_a_d;
  logic [6:0]  duty_b_q, duty_b_d;
  logic        tone_on_q, tone_on_d;
  logic [7:0]  tone_q, tone_d;

  // Result buffer: output register plus holding register for a turn's second result
  logic    out_valid_q;
  logic    pend_q;
  result_t out_q;
  result_t pend_res_q;
  result_t res0, res1;
  logic    turn;

  logic accept;
  logic take;
  logic cfg_wr;

  logic [6:0]  pct;
  logic [15:0] wait_prod;

  assign take   = out_valid_q && result_o.ready;
  assign instr_i.ready = !pend_q && (!out_valid_q || result_o.ready);
  assign accept = instr_i.valid && instr_i.ready;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_SIDE_B_TRIM: prdata = {25'd0, corr_q};
      REG_WAIT_SCALE:  prdata = {24'd0, scale_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q  <= SIDE_B_TRIM_RST;
      scale_q <= WAIT_SCALE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SIDE_B_TRIM) begin
        corr_q <= pwdata[6:0];
      end else begin
        scale_q <= pwdata[7:0];
      end
    end
  end

  // Operand arithmetic
  assign pct       = duty_pct(instr_i.operand);
  assign wait_prod = {8'd0, instr_i.operand} * {8'd0, scale_q};

  // Decode and next state
  always_comb begin
    pa_d         = pa_q;
    started_d    = started_q;
    stopped_d    = stopped_q;
    loop_start_d = loop_start_q;
    loop_rem_d   = loop_rem_q;
    led_d        = led_q;
    dirs_d       = dirs_q;
    duty_a_d     = duty_a_q;
    duty_b_d     = duty_b_q;
    tone_on_d    = tone_on_q;
    tone_d       = tone_q;
    turn         = 1'b0;
    res0         = '0;
    res0.timer_wait = 16'd0;
    res0.delay_ms   = 10'd0;
    res0.last       = 1'b1;

    if (!stopped_q) begin
      pa_d = pa_q + 16'd2;
      if (instr_i.opcode == OP_START) begin
        started_d = 1'b1;
      end
      if (started_d) begin
        case (instr_i.opcode)
          OP_END:  stopped_d = 1'b1;
          OP_WAIT: res0.timer_wait = wait_prod;
          OP_LED_ON: begin
            if (instr_i.operand == 8'd1) begin
              led_d = LED_GREEN;
            end else if (instr_i.operand == 8'd2) begin
              led_d = LED_RED;
            end
          end
          OP_LED_OFF: led_d = LED_OFF;
          OP_FORWARD: begin
            dirs_d   = DIRS_FWD;
            duty_a_d = pct;
            duty_b_d = side_b_duty(pct, corr_q);
          end
          OP_REVERSE: begin
            dirs_d   = DIRS_REV;
            duty_a_d = pct;
            duty_b_d = pct;
          end
          OP_STOP_A, OP_STOP_B: begin
            duty_a_d = 7'd0;
            duty_b_d = 7'd0;
          end
          OP_TURN_RIGHT, OP_TURN_LEFT: begin
            turn     = 1'b1;
            dirs_d   = (instr_i.opcode == OP_TURN_RIGHT) ? DIRS_RIGHT : DIRS_LEFT;
            duty_a_d = DUTY_FULL;
            duty_b_d = side_b_duty(DUTY_FULL, corr_q);
            res0.delay_ms = TURN_MS;
            res0.last     = 1'b0;
          end
          OP_LOOP_BEGIN: begin
            loop_start_d = pa_d;
            loop_rem_d   = instr_i.operand;
          end
          OP_LOOP_END: begin
            if (loop_rem_q != 8'd0) begin
              loop_rem_d = loop_rem_q - 8'd1;
              pa_d       = loop_start_q;
            end
          end
          OP_NOTE_PLAY: begin
            tone_on_d = 1'b1;
            tone_d    = instr_i.operand;
          end
          OP_NOTE_STOP: tone_on_d = 1'b0;
          default: ;
        endcase
      end
    end

    // First result shows the state as updated
    res0.next_address = pa_d + 16'd2;
    res0.halted       = stopped_d;
    res0.led_color    = led_d;
    res0.dir_a        = dirs_d[0];
    res0.dir_b        = dirs_d[1];
    res0.duty_a       = duty_a_d;
    res0.duty_b       = duty_b_d;
    res0.sound_on     = tone_on_d;
    res0.note         = tone_on_d ? tone_d : 8'd0;

    // Second result of a turn: motors stopped, settle delay
    res1          = res0;
    res1.duty_a   = 7'd0;
    res1.duty_b   = 7'd0;
    res1.delay_ms = SETTLE_MS;
    res1.last     = 1'b1;

    if (turn) begin
      duty_a_d = 7'd0;
      duty_b_d = 7'd0;
    end
  end

  // Program state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q         <= '0;
      started_q    <= 1'b0;
      stopped_q    <= 1'b0;
      loop_start_q <= '0;
      loop_rem_q   <= '0;
      led_q        <= LED_OFF;
      dirs_q       <= '0;
      duty_a_q     <= '0;
      duty_b_q     <= '0;
      tone_on_q    <= 1'b0;
      tone_q       <= '0;
    end else if (accept) begin
      pa_q         <= pa_d;
      started_q    <= started_d;
      stopped_q    <= stopped_d;
      loop_start_q <= loop_start_d;
      loop_rem_q   <= loop_rem_d;
      led_q        <= led_d;
      dirs_q       <= dirs_d;
      duty_a_q     <= duty_a_d;
      duty_b_q     <= duty_b_d;
      tone_on_q    <= tone_on_d;
      tone_q       <= tone_d;
    end
  end

  // Result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      pend_q      <= turn;
    end else if (take) begin
      if (pend_q) begin
        pend_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q      <= res0;
      pend_res_q <= res1;
    end else if (take && pend_q) begin
      out_q <= pend_res_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.next_address = out_q.next_address;
  assign result_o.halted       = out_q.halted;
  assign result_o.led_color    = out_q.led_color;
  assign result_o.dir_a        = out_q.dir_a;
  assign result_o.dir_b        = out_q.dir_b;
  assign result_o.duty_a       = out_q.duty_a;
  assign result_o.duty_b       = out_q.duty_b;
  assign result_o.sound_on     = out_q.sound_on;
  assign result_o.note         = out_q.note;
  assign result_o.timer_wait   = out_q.timer_wait;
  assign result_o.delay_ms     = out_q.delay_ms;
  assign result_o.last         = out_q.last;

  // Checks
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("second turn result held without a first one");

  a_not_last_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> pend_q)
    else $error("non-final result shown with no follow-up result");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("halted flag cleared");

  a_side_b_le_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_b_q <= duty_a_q)
    else $error("side B duty above side A duty");

  a_wait_or_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.delay_ms != 10'd0) |-> (out_q.timer_wait == 16'd0))
    else $error("turn result carries a wait");

endmodule
